@@ hw/rtl/ffsa_pkg.sv @@
package ffsa_pkg;

  localparam int ADDR_W  = 48;
  localparam int SIZE_W  = 13;
  localparam int FREED_W = 10;
  localparam int STAT_W  = 2;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // response status codes
  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BAD_SIZE = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NO_ROOM  = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] block_address;
  } in_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ADDR_W-1:0]  result_address;
    logic [FREED_W-1:0] freed_slots;
  } out_rsp_t;

endpackage

@@ hw/rtl/first_fit_slot_allocator_core.sv @@
// Channel   Dir  Handshake              Payload
// --------  ---  ---------------------  -----------------------------------------
// in_*      in   in_valid / in_ready    in_data   (kind, size_bytes, block_address)
// out_*     out  out_valid / out_ready  out_data  (status, result_address, freed_slots)
// cfg_*     in   cfg_valid / cfg_ready  cfg_data  (region_base, 48 bits)
//
// After reset the slot table is swept to all-free, one entry per cycle, through
// all SLOT_COUNT entries; no request is taken during the sweep (cfg writes are).
// An allocate request divides its size by SLOT_BYTES, checks it, scans the table
// for the first free run of the needed length and tags that run; a bad size
// answers without a scan. A free request scans the whole table. The scan reads
// one slot table entry per cycle. One request is in flight at a time; the response
// register lets the next request enter while a response waits on out_ready.
module first_fit_slot_allocator_core #(
  parameter int SLOT_COUNT = 512,
  parameter int SLOT_BYTES = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ffsa_pkg::in_req_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ffsa_pkg::out_rsp_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ffsa_pkg::ADDR_W-1:0]     cfg_data
);
  import ffsa_pkg::*;

  localparam int IW  = $clog2(SLOT_COUNT);
  localparam int CW  = $clog2(SLOT_COUNT + 1);
  localparam int OW  = IW + $clog2(SLOT_BYTES + 1);
  localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

  // size / SLOT_BYTES by reciprocal: exact for every SIZE_W-bit size
  localparam int L  = $clog2(SLOT_BYTES);
  localparam int SH = SIZE_W + L;
  localparam int RECIP = (2 ** SH + SLOT_BYTES - 1) / SLOT_BYTES;
  localparam int PW = 2 * SIZE_W + 2;

  typedef struct packed {
    logic          used;
    logic [IW-1:0] owner;
  } slot_ent_t;

  typedef enum logic [6:0] {
    ST_CLR   = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_CHK   = 7'b0001000,
    ST_SCAN  = 7'b0010000,
    ST_WRITE = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   region_base_r;
  logic                kind_r, kind_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [ADDR_W-1:0]   diff_r, diff_nxt;
  logic [SIZE_W-1:0]   q_r, q_nxt;
  logic [CW-1:0]       need_r, need_nxt;
  logic [CW-1:0]       run_r, run_nxt;
  logic [IW-1:0]       start_r, start_nxt;
  logic [IW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic                iss_done_r, iss_done_nxt;
  logic                pend_r, pend_nxt;
  logic [IW-1:0]       pidx_r, pidx_nxt;
  logic [IW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [OW-1:0]       off_r, off_nxt;
  logic [CW-1:0]       freed_r, freed_nxt;
  logic [STAT_W-1:0]   status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_rsp_t            out_data_r, out_data_nxt;

  // slot table: one synchronous port each way, registered read
  slot_ent_t           slot_mem [SLOT_COUNT];
  slot_ent_t           rd_data_r;
  logic                rd_en;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  slot_ent_t           wr_data;

  logic [PW-1:0]       q_prod;
  logic [PW-1:0]       q_back;
  logic                size_bad;
  logic [OW-1:0]       own_off;
  logic                own_match;
  logic [IW-1:0]       start_cand;
  logic [CW+FREED_W-1:0] freed_ext;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= slot_mem[rd_ptr_r];
    end
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // quotient estimate and back-multiplied check of the requested size
  assign q_prod   = PW'(size_r) * PW'(RECIP);
  assign q_back   = PW'(q_r) * PW'(SLOT_BYTES);
  assign size_bad = (size_r == '0) || (q_back != PW'(size_r)) ||
                    (32'(q_r) > 32'(SLOT_COUNT));

  // a used slot matches when its tag offset equals address - region_base
  assign own_off    = OW'(rd_data_r.owner) * OW'(SLOT_BYTES);
  assign own_match  = rd_data_r.used && (diff_r == ADDR_W'(own_off));
  assign start_cand = (run_r == '0) ? pidx_r : start_r;
  assign freed_ext  = {{FREED_W{1'b0}}, freed_r};

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    size_nxt      = size_r;
    diff_nxt      = diff_r;
    q_nxt         = q_r;
    need_nxt      = need_r;
    run_nxt       = run_r;
    start_nxt     = start_r;
    rd_ptr_nxt    = rd_ptr_r;
    iss_done_nxt  = iss_done_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    wr_ptr_nxt    = wr_ptr_r;
    off_nxt       = off_r;
    freed_nxt     = freed_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = wr_ptr_r;
    wr_data       = '0;

    // drop the response once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLR: begin
        // sweep the table to free after reset
        wr_en      = 1'b1;
        wr_ptr_nxt = wr_ptr_r + IW'(1);
        if (wr_ptr_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt     = in_data.kind;
          size_nxt     = in_data.size_bytes;
          diff_nxt     = in_data.block_address - region_base_r;
          rd_ptr_nxt   = '0;
          iss_done_nxt = 1'b0;
          pend_nxt     = 1'b0;
          run_nxt      = '0;
          freed_nxt    = '0;
          off_nxt      = '0;
          status_nxt   = STATUS_OK;
          state_nxt    = (in_data.kind == KIND_FREE) ? ST_SCAN : ST_DIV;
        end
      end
      ST_DIV: begin
        q_nxt     = SIZE_W'(q_prod >> SH);
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (size_bad) begin
          status_nxt = STATUS_BAD_SIZE;
          state_nxt  = ST_DONE;
        end else begin
          need_nxt  = CW'(q_r);
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue one read per cycle, evaluate the entry read last cycle
        rd_en    = !iss_done_r;
        pend_nxt = !iss_done_r;
        pidx_nxt = rd_ptr_r;
        if (!iss_done_r) begin
          rd_ptr_nxt = rd_ptr_r + IW'(1);
          if (rd_ptr_r == LAST) begin
            iss_done_nxt = 1'b1;
          end
        end
        if (pend_r) begin
          if (kind_r == KIND_ALLOC) begin
            if (!rd_data_r.used) begin
              start_nxt = start_cand;
              if ((run_r + CW'(1)) == need_r) begin
                run_nxt    = need_r;
                wr_ptr_nxt = start_cand;
                state_nxt  = ST_WRITE;
              end else begin
                run_nxt = run_r + CW'(1);
              end
            end else begin
              run_nxt = '0;
            end
            if ((pidx_r == LAST) &&
                !(!rd_data_r.used && ((run_r + CW'(1)) == need_r))) begin
              status_nxt = STATUS_NO_ROOM;
              state_nxt  = ST_DONE;
            end
          end else begin
            if (own_match) begin
              wr_en     = 1'b1;
              wr_addr   = pidx_r;
              wr_data   = '0;
              freed_nxt = freed_r + CW'(1);
            end
            if (pidx_r == LAST) begin
              state_nxt = ST_DONE;
            end
          end
        end
      end
      ST_WRITE: begin
        // tag the granted run with its start slot
        wr_en         = 1'b1;
        wr_data.used  = 1'b1;
        wr_data.owner = start_r;
        wr_ptr_nxt    = wr_ptr_r + IW'(1);
        run_nxt       = run_r - CW'(1);
        off_nxt       = OW'(start_r) * OW'(SLOT_BYTES);
        if (run_r == CW'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the response register is free
        if (!out_valid_r || out_ready) begin
          out_data_nxt.status         = status_r;
          out_data_nxt.result_address =
            ((kind_r == KIND_ALLOC) && (status_r == STATUS_OK)) ?
            (region_base_r + ADDR_W'(off_r)) : '0;
          out_data_nxt.freed_slots    =
            (kind_r == KIND_FREE) ? freed_ext[FREED_W-1:0] : '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLR;
      region_base_r <= '0;
      wr_ptr_r      <= '0;
      out_valid_r   <= 1'b0;
      iss_done_r    <= 1'b0;
      pend_r        <= 1'b0;
      run_r         <= '0;
      need_r        <= '0;
      freed_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      out_valid_r <= out_valid_nxt;
      iss_done_r  <= iss_done_nxt;
      pend_r      <= pend_nxt;
      run_r       <= run_nxt;
      need_r      <= need_nxt;
      freed_r     <= freed_nxt;
      if (cfg_valid && cfg_ready) begin
        region_base_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    size_r     <= size_nxt;
    diff_r     <= diff_nxt;
    q_r        <= q_nxt;
    start_r    <= start_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    pidx_r     <= pidx_nxt;
    off_r      <= off_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // a run under construction never reaches the requested length in the scan
  a_run_below_need: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && (kind_r == KIND_ALLOC)) |-> (run_r < need_r))
    else $error("allocate scan run reached need without leaving the scan");

  // the write phase starts with the full granted length
  a_write_len: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_WRITE) |-> (run_r == need_r))
    else $error("write phase entered with wrong run length");

  // a response appears only out of the done state
  a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("response raised outside the done state");

  // a free never releases more slots than the table holds
  a_freed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(freed_r) <= 32'(SLOT_COUNT)))
    else $error("freed count beyond table size");

endmodule
